// ===== design/chip8_extension_op_unit_macros.svh =====
// assertion macros for the chip8 extension op unit
`ifndef CHIP8_EXTENSION_OP_UNIT_MACROS_SVH
`define CHIP8_EXTENSION_OP_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CF8X_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CF8X_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cf8x_pkg.sv =====
// shared types and constants for the chip8 extension op unit
package cf8x_pkg;

    localparam int MEMORY_BYTES_DEF = 4096;

    localparam logic [2:0] CMD_EXEC   = 3'd0;
    localparam logic [2:0] CMD_WR_REG = 3'd1;
    localparam logic [2:0] CMD_WR_MEM = 3'd2;
    localparam logic [2:0] CMD_RD_REG = 3'd3;
    localparam logic [2:0] CMD_RD_MEM = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_HANDLED = 2'd1;
    localparam logic [1:0] ST_UNKNOWN     = 2'd2;
    localparam logic [1:0] ST_BAD_MEM     = 2'd3;

    localparam logic [3:0] GRP_5 = 4'h5;
    localparam logic [3:0] GRP_F = 4'hF;
    localparam logic [3:0] N_BASE = 4'h0;
    localparam logic [3:0] N_MUL  = 4'h1;
    localparam logic [3:0] N_DIV  = 4'h2;
    localparam logic [3:0] N_SWAP = 4'h3;
    localparam logic [7:0] NN_MEMCPY  = 8'h50;
    localparam logic [7:0] NN_MEMSET  = 8'h60;
    localparam logic [7:0] NN_RNDSEED = 8'h70;
    localparam logic [3:0] REG_VF = 4'hF;
    localparam logic [7:0] DIV0_FLAG = 8'hFF;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] opcode;
        logic [15:0] index_value;
        logic [3:0]  reg_number;
        logic [7:0]  data_value;
        logic [11:0] mem_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_data;
        logic        seed_valid;
        logic [63:0] seed_value;
    } t_out_item;

    typedef struct packed {
        logic       rd_en;
        logic [3:0] rd_addr;
        logic       wr_en;
        logic [3:0] wr_addr;
        logic [7:0] wr_data;
    } t_rf_req;

endpackage

// ===== design/cf8x_regs.sv =====
// sixteen-entry byte register file, synchronous read, cleared by valid bits
module cf8x_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cf8x_pkg::t_rf_req i_req,
    output logic [7:0]        o_rd_data
);
    logic [7:0]  r_mem [0:15];
    logic [15:0] r_valid;
    logic [7:0]  r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : 8'd0;
        end
    end

    assign o_rd_data = r_rd;
endmodule

// ===== design/cf8x_mem.sv =====
// byte memory, one port, registered read
module cf8x_mem #(
    parameter int DEPTH = cf8x_pkg::MEMORY_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wr_data,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd;
endmodule

// ===== design/cf8x_div.sv =====
// 8-bit restoring divider, one quotient bit per cycle
module cf8x_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic       o_done,
    output logic [7:0] o_quo,
    output logic [7:0] o_rem
);
    logic [7:0] r_rem, r_quo, r_b;
    logic [2:0] r_cnt;
    logic       r_busy, r_done;
    logic [8:0] w_sh;
    logic       w_ge;

    assign w_sh = {r_rem, r_quo[7]};
    assign w_ge = (w_sh >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_rem <= w_ge ? 8'(w_sh - {1'b0, r_b}) : w_sh[7:0];
            r_quo <= {r_quo[6:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ===== design/chip8_extension_op_unit.sv =====
// chip8 extension op unit: command sequencer over register file and byte memory
//
// Input beats come on i_in_valid / o_in_stall with a t_in_item payload; one
// result beat per input leaves on o_out_valid / i_out_stall as t_out_item.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// the extensions-enabled bit; write it only while the block is idle.
// One command is worked at a time; o_in_stall is high from acceptance until
// the result has been loaded into the output register. Writes and unhandled
// codes go from decode to the result; in-range reads pass a wait state; SWAP,
// MUL and DIV read Vx and Vy, then write back (DIV runs the bit-serial divider,
// or on divide by zero only writes VF); MEMCPY and MEMSET handle x+1 bytes one
// by one, RNDSEED reads min(x,7)+1 registers; one byte memory access a cycle.
// A result held by i_out_stall stays in the output register; the next command
// may be accepted and worked meanwhile, and waits to load until it is taken.
// Synchronous reset clears the register file (through valid bits), the
// extensions bit and all handshake state; memory bytes are undefined until
// written.
module chip8_extension_op_unit #(
    parameter int MEMORY_BYTES = cf8x_pkg::MEMORY_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cf8x_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cf8x_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int LW = 18;
    localparam logic [LW-1:0] MEM_LIM = LW'(MEMORY_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RDW  = 4'd2;
    localparam logic [3:0] S_RX   = 4'd3;
    localparam logic [3:0] S_RY   = 4'd4;
    localparam logic [3:0] S_SW2  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_WF   = 4'd8;
    localparam logic [3:0] S_CPRD = 4'd9;
    localparam logic [3:0] S_CPWR = 4'd10;
    localparam logic [3:0] S_SETV = 4'd11;
    localparam logic [3:0] S_SET  = 4'd12;
    localparam logic [3:0] S_SEED = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]          r_state, n_state;
    cf8x_pkg::t_in_item  r_item;
    cf8x_pkg::t_out_item r_out;
    logic                r_ov, r_en;
    logic [1:0]          r_status;
    logic [7:0]          r_rd, r_a, r_b, r_hi;
    logic                r_seeded;
    logic [63:0]         r_seed;
    logic [3:0]          r_i;

    cf8x_pkg::t_rf_req rf_req;
    logic [7:0]        rf_rd;
    logic              mem_rd_en, mem_wr_en;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata, mem_rd;
    logic              div_start, div_done;
    logic [7:0]        div_q, div_r;

    logic          in_acc, out_free;
    logic [3:0]    w_grp, w_x, w_y, w_n;
    logic [7:0]    w_nn;
    logic [LW-1:0] w_base, w_cnt, w_src, w_dst, w_maddr;
    logic          w_cpy_bad, w_set_bad, w_maddr_ok, w_ext5, w_extf;
    logic [2:0]    w_seed_last;
    logic [15:0]   w_prod;
    logic [1:0]    w_dec_status;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_ov || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_grp   = r_item.opcode[15:12];
    assign w_x     = r_item.opcode[11:8];
    assign w_y     = r_item.opcode[7:4];
    assign w_n     = r_item.opcode[3:0];
    assign w_nn    = r_item.opcode[7:0];
    assign w_base  = {2'b00, r_item.index_value};
    assign w_cnt   = {14'd0, w_x} + 18'd1;
    assign w_src   = w_base + {14'd0, r_i};
    assign w_dst   = w_src + w_cnt;
    assign w_maddr = {6'd0, r_item.mem_address};
    assign w_cpy_bad  = (w_base + {w_cnt[LW-2:0], 1'b0}) > MEM_LIM;
    assign w_set_bad  = (w_base + w_cnt) > MEM_LIM;
    assign w_maddr_ok = w_maddr < MEM_LIM;
    assign w_seed_last = w_x[3] ? 3'd7 : w_x[2:0];
    assign w_prod = r_a * r_b;

    // enabled extended opcodes: group 5 with MUL, DIV or SWAP; group F with any low byte
    assign w_ext5 = r_en && (w_grp == cf8x_pkg::GRP_5) && (w_n != cf8x_pkg::N_BASE)
                    && (w_n <= cf8x_pkg::N_SWAP);
    assign w_extf = r_en && (w_grp == cf8x_pkg::GRP_F);

    always_comb begin
        w_dec_status = cf8x_pkg::ST_OK;
        case (r_item.command)
            cf8x_pkg::CMD_EXEC: begin
                if (w_grp == cf8x_pkg::GRP_5) begin
                    if (w_n == cf8x_pkg::N_BASE) begin
                        w_dec_status = cf8x_pkg::ST_NOT_HANDLED;
                    end else if (!w_ext5) begin
                        w_dec_status = cf8x_pkg::ST_UNKNOWN;
                    end
                end else if (w_grp == cf8x_pkg::GRP_F) begin
                    if (w_nn != cf8x_pkg::NN_MEMCPY && w_nn != cf8x_pkg::NN_MEMSET
                        && w_nn != cf8x_pkg::NN_RNDSEED) begin
                        w_dec_status = cf8x_pkg::ST_NOT_HANDLED;
                    end else if (!r_en) begin
                        w_dec_status = cf8x_pkg::ST_UNKNOWN;
                    end else if ((w_nn == cf8x_pkg::NN_MEMCPY && w_cpy_bad)
                                 || (w_nn == cf8x_pkg::NN_MEMSET && w_set_bad)) begin
                        w_dec_status = cf8x_pkg::ST_BAD_MEM;
                    end
                end else begin
                    w_dec_status = cf8x_pkg::ST_NOT_HANDLED;
                end
            end
            cf8x_pkg::CMD_WR_REG, cf8x_pkg::CMD_RD_REG: w_dec_status = cf8x_pkg::ST_OK;
            cf8x_pkg::CMD_WR_MEM, cf8x_pkg::CMD_RD_MEM: begin
                if (!w_maddr_ok) w_dec_status = cf8x_pkg::ST_BAD_MEM;
            end
            default: w_dec_status = cf8x_pkg::ST_NOT_HANDLED;
        endcase
    end

    // one access per memory per cycle; each state issues at most one of each
    always_comb begin
        n_state   = r_state;
        rf_req    = '0;
        mem_rd_en = 1'b0;
        mem_wr_en = 1'b0;
        mem_addr  = w_src[AW-1:0];
        mem_wdata = r_a;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_DEC;
            S_DEC: begin
                n_state = S_DONE;
                unique case (r_item.command)
                    cf8x_pkg::CMD_EXEC: begin
                        if (w_ext5) begin
                            rf_req.rd_en   = 1'b1;
                            rf_req.rd_addr = w_x;
                            n_state = S_RX;
                        end else if (w_extf && w_nn == cf8x_pkg::NN_MEMCPY && !w_cpy_bad) begin
                            // byte counter is still being cleared here
                            mem_rd_en = 1'b1;
                            mem_addr  = w_base[AW-1:0];
                            n_state = S_CPWR;
                        end else if (w_extf && w_nn == cf8x_pkg::NN_MEMSET && !w_set_bad) begin
                            rf_req.rd_en = 1'b1;
                            n_state = S_SETV;
                        end else if (w_extf && w_nn == cf8x_pkg::NN_RNDSEED) begin
                            rf_req.rd_en = 1'b1;
                            n_state = S_SEED;
                        end
                    end
                    cf8x_pkg::CMD_WR_REG: begin
                        rf_req.wr_en   = 1'b1;
                        rf_req.wr_addr = r_item.reg_number;
                        rf_req.wr_data = r_item.data_value;
                    end
                    cf8x_pkg::CMD_WR_MEM: begin
                        mem_wr_en = w_maddr_ok;
                        mem_addr  = w_maddr[AW-1:0];
                        mem_wdata = r_item.data_value;
                    end
                    cf8x_pkg::CMD_RD_REG: begin
                        rf_req.rd_en   = 1'b1;
                        rf_req.rd_addr = r_item.reg_number;
                        n_state = S_RDW;
                    end
                    cf8x_pkg::CMD_RD_MEM: begin
                        if (w_maddr_ok) begin
                            mem_rd_en = 1'b1;
                            mem_addr  = w_maddr[AW-1:0];
                            n_state = S_RDW;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RDW: n_state = S_DONE;
            S_RX: begin
                rf_req.rd_en   = 1'b1;
                rf_req.rd_addr = w_y;
                n_state = S_RY;
            end
            S_RY: begin
                n_state = S_DONE;
                case (w_n)
                    cf8x_pkg::N_MUL: n_state = S_MUL;
                    cf8x_pkg::N_DIV: begin
                        if (rf_rd == 8'd0) begin
                            rf_req.wr_en   = 1'b1;
                            rf_req.wr_addr = cf8x_pkg::REG_VF;
                            rf_req.wr_data = cf8x_pkg::DIV0_FLAG;
                        end else begin
                            div_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        rf_req.wr_en   = 1'b1;
                        rf_req.wr_addr = w_x;
                        rf_req.wr_data = rf_rd;
                        n_state = S_SW2;
                    end
                endcase
            end
            S_SW2: begin
                rf_req.wr_en   = 1'b1;
                rf_req.wr_addr = w_y;
                rf_req.wr_data = r_a;
                n_state = S_DONE;
            end
            S_MUL: begin
                rf_req.wr_en   = 1'b1;
                rf_req.wr_addr = w_x;
                rf_req.wr_data = w_prod[7:0];
                n_state = S_WF;
            end
            S_DIV: begin
                if (div_done) begin
                    rf_req.wr_en   = 1'b1;
                    rf_req.wr_addr = w_x;
                    rf_req.wr_data = div_q;
                    n_state = S_WF;
                end
            end
            S_WF: begin
                // VF written last so it wins when x is F
                rf_req.wr_en   = 1'b1;
                rf_req.wr_addr = cf8x_pkg::REG_VF;
                rf_req.wr_data = r_hi;
                n_state = S_DONE;
            end
            S_CPRD: begin
                mem_rd_en = 1'b1;
                n_state = S_CPWR;
            end
            S_CPWR: begin
                // source and destination ranges never overlap
                mem_wr_en = 1'b1;
                mem_addr  = w_dst[AW-1:0];
                mem_wdata = mem_rd;
                n_state = (r_i == w_x) ? S_DONE : S_CPRD;
            end
            S_SETV: n_state = S_SET;
            S_SET: begin
                mem_wr_en = 1'b1;
                n_state = (r_i == w_x) ? S_DONE : S_SET;
            end
            S_SEED: begin
                if (r_i[2:0] == w_seed_last) begin
                    n_state = S_DONE;
                end else begin
                    rf_req.rd_en   = 1'b1;
                    rf_req.rd_addr = r_i + 4'd1;
                end
            end
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_en    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_en <= i_cfg_data;
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (in_acc) r_item <= i_in_item;
            S_DEC: begin
                r_status <= w_dec_status;
                r_rd     <= 8'd0;
                r_seed   <= 64'd0;
                r_seeded <= (r_item.command == cf8x_pkg::CMD_EXEC) && w_extf
                            && (w_nn == cf8x_pkg::NN_RNDSEED);
                r_i      <= 4'd0;
            end
            S_RDW: r_rd <= (r_item.command == cf8x_pkg::CMD_RD_REG) ? rf_rd : mem_rd;
            S_RX:  r_a  <= rf_rd;
            S_RY:  r_b  <= rf_rd;
            S_MUL: r_hi <= w_prod[15:8];
            S_DIV: if (div_done) r_hi <= div_r;
            S_CPWR: r_i <= r_i + 4'd1;
            S_SETV: r_a <= rf_rd;
            S_SET:  r_i <= r_i + 4'd1;
            S_SEED: begin
                r_seed <= {r_seed[55:0], rf_rd};
                r_i    <= r_i + 4'd1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.status     <= r_status;
                    r_out.read_data  <= r_rd;
                    r_out.seed_valid <= r_seeded;
                    r_out.seed_value <= r_seed;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    cf8x_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rf_req),
        .o_rd_data (rf_rd)
    );

    cf8x_mem #(
        .DEPTH (MEMORY_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_wr_en   (mem_wr_en),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wdata),
        .o_rd_data (mem_rd)
    );

    cf8x_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_a),
        .i_b     (rf_rd),
        .o_done  (div_done),
        .o_quo   (div_q),
        .o_rem   (div_r)
    );

`include "chip8_extension_op_unit_macros.svh"

    `CF8X_ASSERT_NXT(a_stall_after_accept, i_clk, i_rst_n, in_acc, o_in_stall,
        "input not stalled after accepted beat")
    `CF8X_ASSERT_IMP(a_seed_ok, i_clk, i_rst_n, o_out_valid && o_out_item.seed_valid,
        o_out_item.status == cf8x_pkg::ST_OK, "seed beat without ok status")
    `CF8X_ASSERT_IMP(a_badmem_zero, i_clk, i_rst_n,
        o_out_valid && o_out_item.status == cf8x_pkg::ST_BAD_MEM,
        o_out_item.read_data == 8'd0 && !o_out_item.seed_valid,
        "bad memory beat carries data")
endmodule
